// ----- hw/rtl/rrf_pkg.sv -----
// Shared types and constants for the rectangle raster fill block.
// Holds the channel word structs, operation/status codes and the control states.
// No dependencies.
package rrf_pkg;

    localparam int C_MAX_SIDE  = 512;
    localparam int C_FRAC_BITS = 8;
    localparam int C_SIDE_W    = $clog2(C_MAX_SIDE);
    localparam int C_ADDR_W    = 2 * C_SIDE_W;
    localparam int C_DEPTH     = C_MAX_SIDE * C_MAX_SIDE;
    localparam int C_COORD_W   = 26;

    localparam logic [1:0] C_OP_CLEAR = 2'd0;
    localparam logic [1:0] C_OP_DRAW  = 2'd1;
    localparam logic [1:0] C_OP_READ  = 2'd2;

    localparam logic [1:0] C_ST_OK      = 2'd0;
    localparam logic [1:0] C_ST_REJECT  = 2'd1;
    localparam logic [1:0] C_ST_OUTSIDE = 2'd2;

    localparam logic [7:0] C_MODE_FILL = 8'h52;
    localparam logic [7:0] C_MODE_LINE = 8'h72;

    localparam logic [1:0] C_CFG_WIDTH  = 2'd0;
    localparam logic [1:0] C_CFG_HEIGHT = 2'd1;
    localparam logic [1:0] C_CFG_BG     = 2'd2;

    localparam logic [9:0] C_SIZE_RESET = 10'd300;
    localparam logic [7:0] C_BG_RESET   = 8'd32;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         shape_mode;
        logic signed [23:0] rect_left;
        logic signed [23:0] rect_top;
        logic [22:0]        rect_span_x;
        logic [22:0]        rect_span_y;
        logic [7:0]         paint_char;
        logic [8:0]         read_col;
        logic [8:0]         read_row;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] pixel_value;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RDWAIT,
        ST_FINISH
    } t_state;

endpackage

// ----- hw/rtl/rrf_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
module rrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/rrf_cover.sv -----
// Pixel coverage test: holds the box bounds of one draw word and tests a pixel.
// Depends on rrf_pkg.
module rrf_cover (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  rrf_pkg::t_in_word            i_word,
    input  logic [rrf_pkg::C_SIDE_W-1:0] i_col,
    input  logic [rrf_pkg::C_SIDE_W-1:0] i_row,
    output logic                         o_hit
);

    localparam int CW = rrf_pkg::C_COORD_W;
    localparam logic signed [CW-1:0] ONE = CW'(1) <<< rrf_pkg::C_FRAC_BITS;

    logic signed [CW-1:0] r_lo_x, r_hi_x, r_ilo_x, r_ihi_x;
    logic signed [CW-1:0] r_lo_y, r_hi_y, r_ilo_y, r_ihi_y;
    logic                 r_outline;
    logic signed [CW-1:0] n_lo_x, n_hi_x, n_lo_y, n_hi_y;
    logic signed [CW-1:0] px, py;
    logic                 in_box, edge_hit;

    always_comb begin
        n_lo_x = CW'(i_word.rect_left);
        n_lo_y = CW'(i_word.rect_top);
        n_hi_x = n_lo_x + $signed({{(CW-23){1'b0}}, i_word.rect_span_x});
        n_hi_y = n_lo_y + $signed({{(CW-23){1'b0}}, i_word.rect_span_y});
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lo_x    <= n_lo_x;
            r_hi_x    <= n_hi_x;
            r_ilo_x   <= n_lo_x + ONE;
            r_ihi_x   <= n_hi_x - ONE;
            r_lo_y    <= n_lo_y;
            r_hi_y    <= n_hi_y;
            r_ilo_y   <= n_lo_y + ONE;
            r_ihi_y   <= n_hi_y - ONE;
            r_outline <= (i_word.shape_mode == rrf_pkg::C_MODE_LINE);
        end
    end

    always_comb begin
        px = $signed({{(CW-rrf_pkg::C_SIDE_W){1'b0}}, i_col}) <<< rrf_pkg::C_FRAC_BITS;
        py = $signed({{(CW-rrf_pkg::C_SIDE_W){1'b0}}, i_row}) <<< rrf_pkg::C_FRAC_BITS;
        in_box   = (px >= r_lo_x) && (px <= r_hi_x) && (py >= r_lo_y) && (py <= r_hi_y);
        edge_hit = (px < r_ilo_x) || (px > r_ihi_x) || (py < r_ilo_y) || (py > r_ihi_y);
        o_hit    = in_box && (!r_outline || edge_hit);
    end

endmodule

// ----- hw/rtl/rectangle_raster_fill.sv -----
// Top level of the rectangle raster fill block: control FSM, config registers,
// output register. Depends on rrf_pkg, rrf_ram and rrf_cover.
//
// Usage: words enter on i_in_valid/o_in_stall and results leave on
// o_out_valid/i_out_stall; every input word gives exactly one result word.
// Config registers (width, height, background) are to be written through
// i_cfg_we/i_cfg_index/i_cfg_data only while idle; the block does not enforce this.
// The canvas lives in one 512x512 byte RAM; clear and draw sweep the canvas in
// use one pixel per cycle through its single write port.
// Clear/draw: the word walks the canvas in ST_WALK, then ST_FINISH places the result.
// Read: ST_RDWAIT takes the registered RAM read data, then ST_FINISH places it.
// Empty canvas, rejected word or read outside the canvas: straight to ST_FINISH.
// The next word is taken at the soonest in the cycle after the last result is placed.
// One word is in work at a time; o_in_stall is high until the result is
// placed in the output register, which may still hold an untaken result.
// A stalled result holds in the output register; a finished word waits for
// that register to free before the next word is taken.
// Reset clears control state and sets width/height to 300 and background to
// 32; canvas contents are undefined until written.
module rectangle_raster_fill (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rrf_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rrf_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data
);

    localparam int SW = rrf_pkg::C_SIDE_W;

    rrf_pkg::t_state    r_state, n_state;
    logic [SW-1:0]      r_col, n_col, r_row, n_row;
    logic [1:0]         r_status, n_status;
    logic [7:0]         r_pix, n_pix;
    logic [7:0]         r_char, n_char;
    logic               r_clear, n_clear;
    logic               r_out_valid, n_out_valid;
    rrf_pkg::t_out_word r_out_word, n_out_word;
    logic [9:0]         r_width, r_height;
    logic [7:0]         r_bg;

    logic [9:0]                   w, h;
    logic                         accept, hit, last_col, last_row, mode_ok, empty;
    logic                         ram_we;
    logic [rrf_pkg::C_ADDR_W-1:0] ram_addr;
    logic [7:0]                   ram_rdata;

    assign accept = i_in_valid && (r_state == rrf_pkg::ST_IDLE);
    assign w = (r_width  > 10'(rrf_pkg::C_MAX_SIDE)) ? 10'(rrf_pkg::C_MAX_SIDE) : r_width;
    assign h = (r_height > 10'(rrf_pkg::C_MAX_SIDE)) ? 10'(rrf_pkg::C_MAX_SIDE) : r_height;
    assign empty    = (w == 10'd0) || (h == 10'd0);
    assign last_col = ({1'b0, r_col} == w - 10'd1);
    assign last_row = ({1'b0, r_row} == h - 10'd1);
    assign mode_ok  = ((i_in_word.shape_mode == rrf_pkg::C_MODE_FILL) ||
                       (i_in_word.shape_mode == rrf_pkg::C_MODE_LINE)) &&
                      (i_in_word.rect_span_x != 23'd0) && (i_in_word.rect_span_y != 23'd0);

    rrf_cover u_cover (
        .i_clk  (i_clk),
        .i_load (accept),
        .i_word (i_in_word),
        .i_col  (r_col),
        .i_row  (r_row),
        .o_hit  (hit)
    );

    assign ram_we   = (r_state == rrf_pkg::ST_WALK) && (r_clear || hit);
    assign ram_addr = (r_state == rrf_pkg::ST_IDLE) ? {i_in_word.read_row, i_in_word.read_col}
                                                    : {r_row, r_col};

    rrf_ram #(
        .WIDTH (8),
        .DEPTH (rrf_pkg::C_DEPTH)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_char),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_status    = r_status;
        n_pix       = r_pix;
        n_char      = r_char;
        n_clear     = r_clear;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        case (r_state)
            rrf_pkg::ST_IDLE: begin
                if (accept) begin
                    n_status = rrf_pkg::C_ST_OK;
                    n_pix    = 8'd0;
                    n_col    = '0;
                    n_row    = '0;
                    n_state  = rrf_pkg::ST_FINISH;
                    case (i_in_word.operation)
                        rrf_pkg::C_OP_CLEAR: begin
                            n_clear = 1'b1;
                            n_char  = r_bg;
                            if (!empty) begin
                                n_state = rrf_pkg::ST_WALK;
                            end
                        end
                        rrf_pkg::C_OP_DRAW: begin
                            n_clear = 1'b0;
                            n_char  = i_in_word.paint_char;
                            if (!mode_ok) begin
                                n_status = rrf_pkg::C_ST_REJECT;
                            end else if (!empty) begin
                                n_state = rrf_pkg::ST_WALK;
                            end
                        end
                        rrf_pkg::C_OP_READ: begin
                            if ({1'b0, i_in_word.read_col} >= w ||
                                {1'b0, i_in_word.read_row} >= h) begin
                                n_status = rrf_pkg::C_ST_OUTSIDE;
                            end else begin
                                n_state = rrf_pkg::ST_RDWAIT;
                            end
                        end
                        default: begin
                            n_status = rrf_pkg::C_ST_REJECT;
                        end
                    endcase
                end
            end
            rrf_pkg::ST_WALK: begin
                if (last_col) begin
                    n_col = '0;
                    if (last_row) begin
                        n_row   = '0;
                        n_state = rrf_pkg::ST_FINISH;
                    end else begin
                        n_row = r_row + SW'(1);
                    end
                end else begin
                    n_col = r_col + SW'(1);
                end
            end
            rrf_pkg::ST_RDWAIT: begin
                n_pix   = ram_rdata;
                n_state = rrf_pkg::ST_FINISH;
            end
            rrf_pkg::ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid            = 1'b1;
                    n_out_word.status      = r_status;
                    n_out_word.pixel_value = r_pix;
                    n_state                = rrf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rrf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrf_pkg::ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
            r_width     <= rrf_pkg::C_SIZE_RESET;
            r_height    <= rrf_pkg::C_SIZE_RESET;
            r_bg        <= rrf_pkg::C_BG_RESET;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rrf_pkg::C_CFG_WIDTH:  r_width  <= i_cfg_data;
                    rrf_pkg::C_CFG_HEIGHT: r_height <= i_cfg_data;
                    rrf_pkg::C_CFG_BG:     r_bg     <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_pix      <= n_pix;
        r_char     <= n_char;
        r_clear    <= n_clear;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = (r_state != rrf_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
